@@ sv/hrpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Hue ring pixel generator package
// Shared widths, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hrpg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int HUE_BITS_DEF   = 12;

  localparam int DIM_W    = 13;
  localparam int BAND_W   = 12;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int RGB_W    = 24;
  localparam int HUE_W    = 12;
  localparam int ANG_BITS = 24;
  localparam int ITERS    = 16;
  localparam int GUARD    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_DIAM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH  = 2'd3;

  localparam logic [DIM_W-1:0]  RST_AREA_WIDTH  = 13'd240;
  localparam logic [DIM_W-1:0]  RST_AREA_HEIGHT = 13'd240;
  localparam logic [DIM_W-1:0]  RST_OUTER_DIAM  = 13'd240;
  localparam logic [BAND_W-1:0] RST_BAND_WIDTH  = 12'd50;

  function automatic logic [ANG_BITS-1:0] atan_turn(input logic [3:0] i);
    logic [ANG_BITS-1:0] t;
    unique case (i)
      4'd0:  t = 24'd2097152;
      4'd1:  t = 24'd1238021;
      4'd2:  t = 24'd654136;
      4'd3:  t = 24'd332050;
      4'd4:  t = 24'd166669;
      4'd5:  t = 24'd83416;
      4'd6:  t = 24'd41718;
      4'd7:  t = 24'd20860;
      4'd8:  t = 24'd10430;
      4'd9:  t = 24'd5215;
      4'd10: t = 24'd2608;
      4'd11: t = 24'd1304;
      4'd12: t = 24'd652;
      4'd13: t = 24'd326;
      4'd14: t = 24'd163;
      default: t = 24'd81;
    endcase
    return t;
  endfunction

endpackage

@@ sv/hrpg_cordic.sv @@
// ----------------------------------------------------------------------------
// Hue ring CORDIC arctangent
// Pipelined vectoring CORDIC, one iteration per stage, with a side-band
// that rides along with each transaction.
// ----------------------------------------------------------------------------
module hrpg_cordic #(
  parameter int VEC_W = 16,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic signed [VEC_W-1:0]       in_x,
  input  logic signed [VEC_W-1:0]       in_y,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [hrpg_pkg::ANG_BITS-1:0] out_angle,
  output logic [SIDE_W-1:0]             out_side
);
  import hrpg_pkg::*;

  // Guard bits plus growth headroom; x grows by at most about 1.65.
  localparam int W = VEC_W + GUARD + 2;

  logic signed [W-1:0]   xs [ITERS+1];
  logic signed [W-1:0]   ys [ITERS+1];
  logic [ANG_BITS-1:0]   zs [ITERS+1];
  logic [SIDE_W-1:0]     sd [ITERS+1];
  logic                  vs [ITERS+1];
  logic signed [W-1:0]   x0;
  logic signed [W-1:0]   y0;

  // Pre-rotation: a left half-plane vector is negated, starting at half a turn.
  always_comb begin
    x0 = {{(W-VEC_W-GUARD){in_x[VEC_W-1]}}, in_x, {GUARD{1'b0}}};
    y0 = {{(W-VEC_W-GUARD){in_y[VEC_W-1]}}, in_y, {GUARD{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (advance) begin
      vs[0] <= in_valid;
    end
    if (advance) begin
      sd[0] <= in_side;
      if (in_x[VEC_W-1]) begin
        xs[0] <= -x0;
        ys[0] <= -y0;
        zs[0] <= ANG_BITS'(1) << (ANG_BITS - 1);
      end else begin
        xs[0] <= x0;
        ys[0] <= y0;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    logic signed [W-1:0] xsh;
    logic signed [W-1:0] ysh;
    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (advance) begin
        vs[i+1] <= vs[i];
      end
      if (advance) begin
        sd[i+1] <= sd[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + ysh;
          ys[i+1] <= ys[i] - xsh;
          zs[i+1] <= zs[i] + atan_turn(4'(i));
        end else begin
          xs[i+1] <= xs[i] - ysh;
          ys[i+1] <= ys[i] + xsh;
          zs[i+1] <= zs[i] - atan_turn(4'(i));
        end
      end
    end
  end

  assign out_valid = vs[ITERS];
  assign out_angle = zs[ITERS];
  assign out_side  = sd[ITERS];

endmodule

@@ sv/hue_ring_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// Hue ring pixel generator
// Colors each in-band pixel by its angle on a hue ring, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// One pixel coordinate is accepted every clock unless the output stalls; its
// color passes through the geometry stages, the CORDIC pipeline and the hue
// rounding and color stages before it comes out.
// A stall on the output freezes the whole pipeline; one output register and
// a skid-free global enable keep every transaction in order and lossless.
module hue_ring_pixel_generator_core #(
  parameter int COORD_BITS = hrpg_pkg::COORD_BITS_DEF,
  parameter int HUE_BITS   = hrpg_pkg::HUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [hrpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrpg_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [11:0]                     pixel_x,
  input  logic [11:0]                     pixel_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hrpg_pkg::RGB_W-1:0]      rgb_word,
  output logic                            in_band,
  output logic [hrpg_pkg::HUE_W-1:0]      hue_code
);
  import hrpg_pkg::*;

  localparam int VEC_W = 15;   // doubled coordinates, signed
  localparam int SQ_W  = 30;
  localparam int LO_W  = 15;
  // Coordinates wider than the ports simply use every port bit.
  localparam int PX_W  = (COORD_BITS < 12) ? COORD_BITS : 12;

  logic [DIM_W-1:0]  area_width;
  logic [DIM_W-1:0]  area_height;
  logic [DIM_W-1:0]  outer_diameter;
  logic [BAND_W-1:0] band_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width     <= RST_AREA_WIDTH;
      area_height    <= RST_AREA_HEIGHT;
      outer_diameter <= RST_OUTER_DIAM;
      band_width     <= RST_BAND_WIDTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AREA_WIDTH:  area_width     <= cfg_data;
        REG_AREA_HEIGHT: area_height    <= cfg_data;
        REG_OUTER_DIAM:  outer_diameter <= cfg_data;
        default:         band_width     <= cfg_data[BAND_W-1:0];
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held.
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Stage 1: doubled offsets and band bounds.
  logic                    v1;
  logic signed [VEC_W-1:0] dx1, dy1;
  logic signed [LO_W-1:0]  lo1;
  logic [LO_W-1:0]         hi1;
  logic [PX_W-1:0]         px, py;
  assign px = pixel_x[PX_W-1:0];
  assign py = pixel_y[PX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (advance) v1 <= in_valid;
    if (advance) begin
      dx1 <= VEC_W'({px, 1'b0}) - VEC_W'(area_width);
      dy1 <= VEC_W'(area_height) - VEC_W'({py, 1'b0});
      lo1 <= LO_W'(outer_diameter) - LO_W'({band_width, 1'b0}) - LO_W'(2);
      hi1 <= LO_W'(outer_diameter) + LO_W'(2);
    end
  end

  // Stage 2: squares.
  logic                    v2;
  logic signed [VEC_W-1:0] dx2, dy2;
  logic [SQ_W-1:0]         sx2, sy2, lo2, hi2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (advance) v2 <= v1;
    if (advance) begin
      dx2 <= dx1;
      dy2 <= dy1;
      sx2 <= SQ_W'(dx1 * dx1);
      sy2 <= SQ_W'(dy1 * dy1);
      lo2 <= SQ_W'(lo1 * lo1);
      hi2 <= SQ_W'(hi1 * hi1);
    end
  end

  // Stage 3: band test.
  logic                    v3;
  logic signed [VEC_W-1:0] dx3, dy3;
  logic                    band3;
  logic [SQ_W:0]           dsum;
  assign dsum = {1'b0, sx2} + {1'b0, sy2};
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (advance) v3 <= v2;
    if (advance) begin
      dx3   <= dx2;
      dy3   <= dy2;
      band3 <= !(dsum < {1'b0, lo2}) && !(dsum > {1'b0, hi2});
    end
  end

  // CORDIC stages; the side band carries the band flag and the center flag.
  logic                v4;
  logic [ANG_BITS-1:0] ang4;
  logic [1:0]          side4;
  hrpg_cordic #(.VEC_W(VEC_W), .SIDE_W(2)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v3),
    .in_x      (dx3),
    .in_y      (dy3),
    .in_side   ({band3, (dx3 == '0) && (dy3 == '0)}),
    .out_valid (v4),
    .out_angle (ang4),
    .out_side  (side4)
  );

  // Hue rounding and sector split.
  localparam int H6_W = HUE_BITS + 3;
  logic                v5;
  logic                band5;
  logic [HUE_BITS-1:0] hue5;
  logic [ANG_BITS:0]   zround;
  assign zround = {1'b0, ang4} + ((ANG_BITS+1)'(1) << (ANG_BITS - HUE_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (advance) v5 <= v4;
    if (advance) begin
      band5 <= side4[1];
      if (side4[0]) hue5 <= '0;
      else hue5 <= zround[ANG_BITS-1 -: HUE_BITS];
    end
  end

  logic                v6;
  logic                band6;
  logic [HUE_BITS-1:0] hue6;
  logic [2:0]          sec6;
  logic [HUE_BITS-1:0] f6;
  logic [H6_W-1:0]     h6;
  assign h6 = H6_W'(hue5) * H6_W'(6);
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (advance) v6 <= v5;
    if (advance) begin
      band6 <= band5;
      hue6  <= hue5;
      sec6  <= h6[H6_W-1 -: 3];
      f6    <= h6[HUE_BITS-1:0];
    end
  end

  // Channel ramps.
  localparam int M_W = HUE_BITS + 9;
  logic [M_W-1:0] upm, dnm;
  assign upm = M_W'(f6) * M_W'(255) + (M_W'(1) << (HUE_BITS - 1));
  assign dnm = ((M_W'(1) << HUE_BITS) - M_W'(f6)) * M_W'(255)
               + (M_W'(1) << (HUE_BITS - 1));
  logic [7:0] up, dn;
  assign up = upm[HUE_BITS +: 8];
  assign dn = dnm[HUE_BITS +: 8];

  logic [7:0] r, g, b;
  always_comb begin
    unique case (sec6)
      3'd0: begin r = 8'hFF; g = up;    b = 8'h00; end
      3'd1: begin r = dn;    g = 8'hFF; b = 8'h00; end
      3'd2: begin r = 8'h00; g = 8'hFF; b = up;    end
      3'd3: begin r = 8'h00; g = dn;    b = 8'hFF; end
      3'd4: begin r = up;    g = 8'h00; b = 8'hFF; end
      default: begin r = 8'hFF; g = 8'h00; b = dn; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= v6;
    if (advance) begin
      in_band  <= band6;
      rgb_word <= band6 ? {r, g, b} : '0;
      hue_code <= band6 ? HUE_W'(hue6) : '0;
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hue ring pixel generator testbench
// Drives pixel coordinates under several ring geometries with random gaps
// and output stalls, and checks every color against a built-in predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import hrpg_pkg::*;

  localparam int LATENCY = 22;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic             band;
    logic [HUE_W-1:0] hue;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_AREA_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RGB_W-1:0] rgb_word;
  logic in_band;
  logic [HUE_W-1:0] hue_code;

  // Shadow copy of the geometry registers.
  logic [12:0] geo_w, geo_h, geo_s;
  logic [11:0] geo_b;

  color_t pending_colors[$];
  int mismatches = 0;
  int hold_cycles = 0;
  bit stall_random = 1'b1;

  hue_ring_pixel_generator_core uut (.*);

  always #2 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [11:0] angle_code(longint dx2, longint dy2);
    longint x, y, xs, ys;
    logic [23:0] z;
    if (dx2 == 0 && dy2 == 0) return '0;
    x = dx2 * 65536;
    y = dy2 * 65536;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 24'h800000;
    end
    for (int i = 0; i < ITERS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_turn(i[3:0]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_turn(i[3:0]);
      end
    end
    z = z + 24'd2048;
    return z[23:12];
  endfunction

  function automatic logic [23:0] wheel_color(logic [11:0] hue);
    int h6, sector, f, up, down;
    int r, g, b;
    h6 = hue * 6;
    sector = h6 >> 12;
    f = h6 & 4095;
    up = (f * 255 + 2048) >> 12;
    down = ((4096 - f) * 255 + 2048) >> 12;
    unique case (sector)
      0: begin r = 255; g = up; b = 0; end
      1: begin r = down; g = 255; b = 0; end
      2: begin r = 0; g = 255; b = up; end
      3: begin r = 0; g = down; b = 255; end
      4: begin r = up; g = 0; b = 255; end
      default: begin r = 255; g = 0; b = down; end
    endcase
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  function automatic color_t pixel_color(logic [11:0] px, logic [11:0] py);
    longint dx2, dy2, d, lo, hi;
    color_t c;
    dx2 = 2 * longint'(px) - longint'(geo_w);
    dy2 = longint'(geo_h) - 2 * longint'(py);
    d = dx2 * dx2 + dy2 * dy2;
    lo = longint'(geo_s) - 2 * longint'(geo_b) - 2;
    hi = longint'(geo_s) + 2;
    c = '0;
    if (d >= lo * lo && d <= hi * hi) begin
      c.hue = angle_code(dx2, dy2);
      c.rgb = wheel_color(c.hue);
      c.band = 1'b1;
    end
    return c;
  endfunction

  // A gap drops valid; with no gap the next transaction follows at once.
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    in_valid <= 1'b1;
    pixel_x <= px;
    pixel_y <= py;
    do @(posedge clk); while (in_stall);
    pending_colors.push_back(pixel_color(px, py));
    @(negedge clk);
    if (stall_random) random_gap();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_colors.size() > 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_geometry(logic [12:0] w, logic [12:0] h, logic [12:0] s,
                                logic [11:0] b);
    logic [12:0] vals[4];
    vals = '{w, h, s, {1'b0, b}};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    geo_w = w; geo_h = h; geo_s = s; geo_b = b;
  endtask

  task automatic test_directed();
    logic [11:0] ex[6] = '{0, 4095, 120, 120, 0, 239};
    logic [11:0] ey[6] = '{0, 4095, 0, 239, 120, 120};
    for (int i = 0; i < 6; i++) send_pixel(ex[i], ey[i]);
    // Center pixel lies outside the band when the hole radius is negative, as the inner bound is squared.
    write_geometry(13'd240, 13'd240, 13'd20, 12'd2048);
    send_pixel(12'd120, 12'd120);
    send_pixel(12'd121, 12'd120);
    // Half-pixel center with odd sizes, all four quadrant axes.
    write_geometry(13'd9, 13'd9, 13'd8, 12'd1);
    for (int i = 0; i < 9; i++) send_pixel(i[11:0], 12'd4);
    for (int i = 0; i < 9; i++) send_pixel(12'd4, i[11:0]);
  endtask

  // Most pixels are drawn near the ring so that the band is hit often.
  task automatic test_random(int count);
    int cx, cy, r, a;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pixel(12'($urandom), 12'($urandom));
      end else begin
        cx = geo_w / 2; cy = geo_h / 2;
        r = geo_s / 2 + 2;
        a = $urandom_range(0, 2 * r + 2);
        send_pixel(12'(cx - r - 1 + $urandom_range(0, 2 * r + 2)),
                   12'(cy - r - 1 + a));
      end
    end
  endtask

  task automatic test_geometries();
    write_geometry(13'd4096, 13'd4096, 13'd4096, 12'd2048);
    test_random(150);
    write_geometry(13'd1, 13'd1, 13'd2, 12'd1);
    test_random(60);
    write_geometry(13'h1FFF, 13'h0, 13'h1FFF, 12'hFFF);
    test_random(60);
    write_geometry(13'd640, 13'd480, 13'd400, 12'd60);
    test_random(250);
    write_geometry(13'd200, 13'd100, 13'd90, 12'd30);
    test_random(150);
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall.
  task automatic test_backpressure();
    hold_cycles = 80;
    stall_random = 1'b0;
    test_random(60);
    stall_random = 1'b1;
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    color_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction rgb=%h", rgb_word);
      end else begin
        want = pending_colors.pop_front();
        if (want.rgb !== rgb_word || want.band !== in_band || want.hue !== hue_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rgb=%h band=%b hue=%0d, got rgb=%h band=%b hue=%0d",
                     want.rgb, want.band, want.hue, rgb_word, in_band, hue_code);
        end
      end
    end
  end

  initial begin
    geo_w = RST_AREA_WIDTH; geo_h = RST_AREA_HEIGHT;
    geo_s = RST_OUTER_DIAM; geo_b = RST_BAND_WIDTH;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    write_geometry(RST_AREA_WIDTH, RST_AREA_HEIGHT, RST_OUTER_DIAM, RST_BAND_WIDTH);
    test_backpressure();
    test_geometries();
    drain();
    if (mismatches == 0 && pending_colors.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
